/* hw/rtl/utf8v_pkg.sv */
`default_nettype none

package utf8v_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CLS_ASCII = 2'd0,
        CLS_LEAD  = 2'd1,
        CLS_CONT  = 2'd2,
        CLS_BAD   = 2'd3
    } cls_kind_t;

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        cls_kind_t  kind;
        logic [1:0] seq_len;
        logic [5:0] payload;
        logic       last;
    } cls_item_t;

endpackage

`default_nettype wire

/* hw/rtl/utf8v_if.sv */
`default_nettype none

interface utf8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8v_result_if;
    logic valid;
    logic ready;
    logic is_valid;

    modport source (output valid, output is_valid, input ready);
    modport sink   (input valid, input is_valid, output ready);
endinterface

`default_nettype wire

/* hw/rtl/utf8v_classify.sv */
`default_nettype none

module utf8v_classify (
    utf8v_byte_if.sink           byte_ch,
    input  wire logic            queue_full,
    output logic                 push,
    output utf8v_pkg::cls_item_t item
);
    import utf8v_pkg::*;

    logic [7:0] b;

    assign b            = byte_ch.data_byte;
    assign byte_ch.ready = !queue_full;
    assign push         = byte_ch.valid && !queue_full;

    // Decode the byte type and strip the marker bits.
    always_comb
    begin
        item.last    = byte_ch.last_byte;
        item.seq_len = 2'd0;
        item.payload = b[5:0];
        if (b[7] == 1'b0)
        begin
            item.kind = CLS_ASCII;
        end
        else if (b[7:6] == 2'b10)
        begin
            item.kind = CLS_CONT;
        end
        else if (b[7:5] == 3'b110)
        begin
            item.kind    = CLS_LEAD;
            item.seq_len = 2'd1;
            item.payload = {1'b0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            item.kind    = CLS_LEAD;
            item.seq_len = 2'd2;
            item.payload = {2'b00, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            item.kind    = CLS_LEAD;
            item.seq_len = 2'd3;
            item.payload = {3'b000, b[2:0]};
        end
        else
        begin
            item.kind = CLS_BAD;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/utf8v_queue.sv */
`default_nettype none

module utf8v_queue #(
    parameter int DEPTH = utf8v_pkg::QUEUE_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire utf8v_pkg::cls_item_t push_item,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      empty,
    output utf8v_pkg::cls_item_t      head
);
    import utf8v_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

endmodule

`default_nettype wire

/* hw/rtl/utf8v_check.sv */
`default_nettype none

module utf8v_check (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 queue_empty,
    input  wire utf8v_pkg::cls_item_t head,
    output logic                      pop,
    utf8v_result_if.source            result_ch
);
    import utf8v_pkg::*;

    localparam logic [20:0] MIN_2     = 21'h000080;
    localparam logic [20:0] MIN_3     = 21'h000800;
    localparam logic [20:0] MIN_4     = 21'h010000;
    localparam logic [20:0] SURR_LO   = 21'h00D800;
    localparam logic [20:0] SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_MAX    = 21'h10FFFF;

    logic [1:0]  pending_reg, pending_next;
    logic [1:0]  seq_len_reg, seq_len_next;
    logic [20:0] acc_reg, acc_next;
    logic        err_reg, err_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_bit_reg, out_bit_next;
    logic [20:0] cp;
    logic [20:0] min_value;
    logic        out_free;

    assign out_free = !out_valid_reg || result_ch.ready;
    // Non-last requests never need the output register.
    assign pop      = !queue_empty && (!head.last || out_free);

    assign result_ch.valid    = out_valid_reg;
    assign result_ch.is_valid = out_bit_reg;

    assign cp = {acc_reg[14:0], head.payload};

    always_comb
    begin
        unique case (seq_len_reg)
            2'd1:    min_value = MIN_2;
            2'd2:    min_value = MIN_3;
            default: min_value = MIN_4;
        endcase
    end

    always_comb
    begin
        pending_next   = pending_reg;
        seq_len_next   = seq_len_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;
        out_bit_next   = out_bit_reg;

        if (pop)
        begin
            if (!err_reg)
            begin
                if (pending_reg == 2'd0)
                begin
                    unique case (head.kind)
                        CLS_ASCII: ;
                        CLS_LEAD:
                        begin
                            seq_len_next = head.seq_len;
                            pending_next = head.seq_len;
                            acc_next     = {15'd0, head.payload};
                        end
                        default:   err_next = 1'b1;
                    endcase
                end
                else if (head.kind != CLS_CONT)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    acc_next     = cp;
                    pending_next = pending_reg - 1'b1;
                    // Range checks once the sequence closes.
                    if (pending_reg == 2'd1)
                    begin
                        if (cp < min_value || (cp >= SURR_LO && cp <= SURR_HI) || cp > CP_MAX)
                        begin
                            err_next = 1'b1;
                        end
                    end
                end
            end

            if (head.last)
            begin
                out_valid_next = 1'b1;
                out_bit_next   = !err_next && (pending_next == 2'd0);
                pending_next   = 2'd0;
                seq_len_next   = 2'd0;
                acc_next       = '0;
                err_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 2'd0;
            seq_len_reg   <= 2'd0;
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            seq_len_reg   <= seq_len_next;
            acc_reg       <= acc_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_bit_reg <= out_bit_next;
    end

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= seq_len_reg)
        else $error("more continuations pending than the sequence holds");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.last) |=> (pending_reg == 2'd0 && !err_reg && out_valid_reg))
        else $error("state not cleared after last request");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ch.ready) |-> !(pop && head.last))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* hw/rtl/utf8_stream_validator_top.sv */
// result_ch.valid is registered: the last byte passes through the queue, then the result register.
// Throughput: one byte per cycle unless the result stalls; the result register frees when taken.
// byte_ch.ready drops only when the two-entry queue is full behind a stalled result.
// Reset (rst_n low, asynchronous) empties the queue, drops the result and clears
// all sequence state; the next byte starts a new buffer.
`default_nettype none

module utf8_stream_validator_top #(
    parameter int QUEUE_DEPTH = utf8v_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    utf8v_byte_if.sink      byte_ch,
    utf8v_result_if.source  result_ch
);
    import utf8v_pkg::*;

    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_empty;
    cls_item_t push_item;
    cls_item_t head;

    utf8v_classify u_classify (
        .byte_ch    (byte_ch),
        .queue_full (queue_full),
        .push       (push),
        .item       (push_item)
    );

    utf8v_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .empty     (queue_empty),
        .head      (head)
    );

    utf8v_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .result_ch   (result_ch)
    );

endmodule

`default_nettype wire
